[hw/rtl/ipd_pkg.sv]
// Package for the pulse distance IR decoder: field widths, frame layout
// constants and parameter defaults. No dependencies.
package ipd_pkg;

  localparam int DUR_W               = 16;
  localparam int BYTE_W              = 8;

  localparam int DEF_MAX_DURATIONS   = 128;
  localparam int DEF_AVERAGE_SAMPLES = 10;

  localparam int MIN_DURATIONS       = 64;
  localparam int SCAN_TAIL           = 10;
  localparam int FRAME_PHASE         = 4;
  localparam int FRAME_PHASE_BITS    = 3;
  localparam int START_MARK_IDX      = 1;
  localparam int START_SPACE_IDX     = 2;
  localparam int FIRST_MARK_IDX      = 3;
  localparam int FIRST_SPACE_IDX     = 4;
  localparam int DUR_STEP            = 2;
  localparam int BYTE_DUR_SHIFT      = 4;
  localparam int HEAD_EXTRA          = 5;

endpackage

[hw/rtl/ipd_store.sv]
// Duration store: single write port, single read port with registered read data.
// Depends on ipd_pkg for the duration width.
module ipd_store #(
  parameter int DEPTH = ipd_pkg::DEF_MAX_DURATIONS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic [ipd_pkg::DUR_W-1:0] wdata,
  input  logic                     re,
  input  logic [AW-1:0]            raddr,
  output logic [ipd_pkg::DUR_W-1:0] rdata
);
  import ipd_pkg::*;

  logic [DUR_W-1:0] mem [DEPTH];
  logic [DUR_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/ipd_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on nothing outside this file.
module ipd_div #(
  parameter int W  = 20,
  parameter int DW = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [W-1:0]  dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [W-1:0]  quotient
);
  localparam int CW = $clog2(W + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] dvs_r;
  logic [W-1:0]  q_r;
  logic [DW:0]   rem_sh;
  logic [DW:0]   diff;
  logic          ge;
  logic [DW-1:0] rem_nxt;

  always_comb begin
    rem_sh  = {rem_r, q_r[W-1]};
    ge      = rem_sh >= {1'b0, dvs_r};
    diff    = rem_sh - {1'b0, dvs_r};
    rem_nxt = ge ? diff[DW-1:0] : rem_sh[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

[hw/rtl/pulse_distance_ir_decoder_unit.sv]
// Pulse distance IR decoder top level: load sequencer, decode walk and output register.
// Depends on ipd_pkg, ipd_store and ipd_div.
//
// Usage: durations arrive on the in_ channel (in_duration, in_frame_end), one per item,
// and are written to the duration store; an item with in_frame_end closes the frame.
// Load items give no result. On a frame end the block stops taking items (in_stall high)
// and walks the store: the short pass reads the bit marks and takes their mean by a
// reciprocal multiply, the long scan reads and checks each space in turn (S_LRD, S_LCHK),
// the long mean is taken on the divider of width SUM_W = 16 + clog2(AVERAGE_SAMPLES + 1),
// or set to zero when no long space is found, and each data byte is built from 8 store
// reads and checks (S_DRD, S_DBIT) plus one emit. The single store read port makes the
// walk read one duration at a time. Results leave on the out_ channel: 6 header items
// then one item per data byte, or one flagged item for a rejected frame; its frame end
// moves the walk to S_REJ, which loads it into the output register once that can take it.
// The output register holds an item while out_stall is high and the walk waits on it.
// Reset empties the frame, clears out_valid and returns to loading; store
// contents are not cleared and need no clearing pass.
module pulse_distance_ir_decoder_unit #(
  parameter int MAX_DURATIONS   = ipd_pkg::DEF_MAX_DURATIONS,
  parameter int AVERAGE_SAMPLES = ipd_pkg::DEF_AVERAGE_SAMPLES
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [ipd_pkg::DUR_W-1:0]  in_duration,
  input  logic                       in_frame_end,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [ipd_pkg::BYTE_W-1:0] out_byte,
  output logic                       out_frame_bad,
  output logic                       out_last_byte
);
  import ipd_pkg::*;

  localparam int AW       = $clog2(MAX_DURATIONS);
  localparam int CNT_W    = $clog2(MAX_DURATIONS + 1);
  localparam int FND_W    = $clog2(AVERAGE_SAMPLES + 1);
  localparam int SUM_W    = DUR_W + FND_W;
  localparam int DC_W     = CNT_W - BYTE_DUR_SHIFT;
  localparam int RECIP_SH = SUM_W + $clog2(AVERAGE_SAMPLES);
  localparam int RECIP_W  = RECIP_SH + 1;
  localparam int PROD_W   = SUM_W + RECIP_W;
  localparam int RECIP_MUL = (2 ** RECIP_SH + AVERAGE_SAMPLES - 1) / AVERAGE_SAMPLES;

  localparam logic [2:0] HDR_LEN    = 3'd0;
  localparam logic [2:0] HDR_SMARK  = 3'd1;
  localparam logic [2:0] HDR_SSPACE = 3'd2;
  localparam logic [2:0] HDR_SHORT  = 3'd3;
  localparam logic [2:0] HDR_LONG   = 3'd4;
  localparam logic [2:0] HDR_COUNT  = 3'd5;

  typedef enum logic [11:0] {
    S_LOAD  = 12'b0000_0000_0001,
    S_REJ   = 12'b0000_0000_0010,
    S_SHORT = 12'b0000_0000_0100,
    S_SDIV  = 12'b0000_0000_1000,
    S_LRD   = 12'b0000_0001_0000,
    S_LCHK  = 12'b0000_0010_0000,
    S_LST   = 12'b0000_0100_0000,
    S_LDIV  = 12'b0000_1000_0000,
    S_HEAD  = 12'b0001_0000_0000,
    S_DRD   = 12'b0010_0000_0000,
    S_DBIT  = 12'b0100_0000_0000,
    S_DEMIT = 12'b1000_0000_0000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               ovf_r, ovf_nxt;
  logic [CNT_W-1:0]   fcnt_r, fcnt_nxt;
  logic [DC_W-1:0]    dc_r, dc_nxt;
  logic [DUR_W-1:0]   smark_r, smark_nxt;
  logic [DUR_W-1:0]   sspace_r, sspace_nxt;
  logic [FND_W-1:0]   k_r, k_nxt;
  logic               rdv_r, rdv_nxt;
  logic [SUM_W-1:0]   ssum_r, ssum_nxt;
  logic [DUR_W-1:0]   short_r, short_nxt;
  logic [DUR_W-1:0]   long_r, long_nxt;
  logic [SUM_W-1:0]   lsum_r, lsum_nxt;
  logic [FND_W-1:0]   found_r, found_nxt;
  logic [CNT_W-1:0]   addr_r, addr_nxt;
  logic [2:0]         h_r, h_nxt;
  logic [2:0]         bit_r, bit_nxt;
  logic [DC_W-1:0]    i_r, i_nxt;
  logic [BYTE_W-1:0]  acc_r, acc_nxt;

  logic               out_valid_r;
  logic [BYTE_W-1:0]  out_byte_r;
  logic               out_bad_r;
  logic               out_last_r;

  logic               can_emit;
  logic               emit_v;
  logic [BYTE_W-1:0]  emit_byte;
  logic               emit_bad;
  logic               emit_last;

  logic               mem_we;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [DUR_W-1:0]   mem_rdata;
  logic [AW-1:0]      short_addr;

  logic               div_start;
  logic [SUM_W-1:0]   div_dividend;
  logic [FND_W-1:0]   div_divisor;
  logic               div_done;
  logic [SUM_W-1:0]   div_q;

  logic [PROD_W-1:0]  short_prod;
  logic               cnt_full;
  logic [CNT_W-1:0]   fin_cnt;
  logic               fin_bad;
  logic [DUR_W:0]     twice_short;
  logic               hit;
  logic [FND_W-1:0]   found_inc;
  logic [CNT_W:0]     scan_next;
  logic [CNT_W:0]     scan_limit;
  logic               dc_zero;
  logic               last_data;

  ipd_store #(
    .DEPTH (MAX_DURATIONS),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (in_duration),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ipd_div #(
    .W  (SUM_W),
    .DW (FND_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    cnt_full     = cnt_r == CNT_W'(MAX_DURATIONS);
    fin_cnt      = cnt_full ? cnt_r : cnt_r + CNT_W'(1);
    fin_bad      = ovf_r || cnt_full || (fin_cnt < CNT_W'(MIN_DURATIONS)) ||
                   (fin_cnt[FRAME_PHASE_BITS-1:0] != FRAME_PHASE_BITS'(FRAME_PHASE));
    short_prod   = PROD_W'(ssum_r) * PROD_W'(RECIP_MUL);
    twice_short  = {short_r, 1'b0};
    hit          = {1'b0, mem_rdata} > twice_short;
    found_inc    = found_r + FND_W'(1);
    scan_next    = (CNT_W+1)'(addr_r) + (CNT_W+1)'(DUR_STEP);
    scan_limit   = (CNT_W+1)'(fcnt_r) - (CNT_W+1)'(SCAN_TAIL);
    dc_zero      = dc_r == '0;
    last_data    = (i_r + DC_W'(1)) == dc_r;
    short_addr   = AW'({k_r, 1'b1}) + AW'(FIRST_MARK_IDX - 1);
    mem_raddr    = (state_r == S_SHORT) ? short_addr : addr_r[AW-1:0];
    can_emit     = !out_valid_r || !out_stall;
    in_stall     = (state_r != S_LOAD) || !rst_n;
    div_dividend = lsum_r;
    div_divisor  = found_r;
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    ovf_nxt    = ovf_r;
    fcnt_nxt   = fcnt_r;
    dc_nxt     = dc_r;
    smark_nxt  = smark_r;
    sspace_nxt = sspace_r;
    k_nxt      = k_r;
    rdv_nxt    = rdv_r;
    ssum_nxt   = ssum_r;
    short_nxt  = short_r;
    long_nxt   = long_r;
    lsum_nxt   = lsum_r;
    found_nxt  = found_r;
    addr_nxt   = addr_r;
    h_nxt      = h_r;
    bit_nxt    = bit_r;
    i_nxt      = i_r;
    acc_nxt    = acc_r;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    div_start  = 1'b0;
    emit_v     = 1'b0;
    emit_byte  = '0;
    emit_bad   = 1'b0;
    emit_last  = 1'b0;
    case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          if (!cnt_full) begin
            mem_we  = 1'b1;
            cnt_nxt = cnt_r + CNT_W'(1);
            if (cnt_r == CNT_W'(START_MARK_IDX)) begin
              smark_nxt = in_duration;
            end
            if (cnt_r == CNT_W'(START_SPACE_IDX)) begin
              sspace_nxt = in_duration;
            end
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_frame_end) begin
            cnt_nxt  = '0;
            ovf_nxt  = 1'b0;
            fcnt_nxt = fin_cnt;
            dc_nxt   = DC_W'((fin_cnt - CNT_W'(FIRST_SPACE_IDX)) >> BYTE_DUR_SHIFT);
            if (fin_bad) begin
              state_nxt = S_REJ;
            end else begin
              k_nxt     = '0;
              rdv_nxt   = 1'b0;
              ssum_nxt  = '0;
              state_nxt = S_SHORT;
            end
          end
        end
      end
      S_REJ: begin
        if (can_emit) begin
          emit_v    = 1'b1;
          emit_bad  = 1'b1;
          emit_last = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_SHORT: begin
        if (k_r != FND_W'(AVERAGE_SAMPLES)) begin
          mem_re  = 1'b1;
          k_nxt   = k_r + FND_W'(1);
          rdv_nxt = 1'b1;
        end else begin
          rdv_nxt = 1'b0;
        end
        if (rdv_r) begin
          ssum_nxt = ssum_r + SUM_W'(mem_rdata);
        end
        if (k_r == FND_W'(AVERAGE_SAMPLES) && !rdv_r) begin
          state_nxt = S_SDIV;
        end
      end
      S_SDIV: begin
        short_nxt = short_prod[RECIP_SH +: DUR_W];
        addr_nxt  = CNT_W'(FIRST_SPACE_IDX);
        found_nxt = '0;
        lsum_nxt  = '0;
        state_nxt = S_LRD;
      end
      S_LRD: begin
        mem_re    = 1'b1;
        state_nxt = S_LCHK;
      end
      S_LCHK: begin
        if (hit) begin
          lsum_nxt  = lsum_r + SUM_W'(mem_rdata);
          found_nxt = found_inc;
        end
        addr_nxt = scan_next[CNT_W-1:0];
        if ((hit && found_inc == FND_W'(AVERAGE_SAMPLES)) || (scan_next > scan_limit)) begin
          state_nxt = S_LST;
        end else begin
          state_nxt = S_LRD;
        end
      end
      S_LST: begin
        if (found_r == '0) begin
          long_nxt  = '0;
          h_nxt     = HDR_LEN;
          state_nxt = S_HEAD;
        end else begin
          div_start = 1'b1;
          state_nxt = S_LDIV;
        end
      end
      S_LDIV: begin
        if (div_done) begin
          long_nxt  = div_q[DUR_W-1:0];
          h_nxt     = HDR_LEN;
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        if (can_emit) begin
          emit_v    = 1'b1;
          emit_last = (h_r == HDR_LONG || h_r == HDR_COUNT) && dc_zero;
          case (h_r)
            HDR_LEN:    emit_byte = BYTE_W'(dc_r) + BYTE_W'(HEAD_EXTRA);
            HDR_SMARK:  emit_byte = smark_r[BYTE_W-1:0];
            HDR_SSPACE: emit_byte = sspace_r[BYTE_W-1:0];
            HDR_SHORT:  emit_byte = short_r[BYTE_W-1:0];
            HDR_LONG:   emit_byte = long_r[BYTE_W-1:0];
            HDR_COUNT:  emit_byte = BYTE_W'(dc_r);
            default:    emit_byte = '0;
          endcase
          h_nxt = h_r + 3'd1;
          if (h_r == HDR_COUNT) begin
            if (dc_zero) begin
              state_nxt = S_LOAD;
            end else begin
              addr_nxt  = CNT_W'(FIRST_SPACE_IDX);
              bit_nxt   = '0;
              i_nxt     = '0;
              acc_nxt   = '0;
              state_nxt = S_DRD;
            end
          end
        end
      end
      S_DRD: begin
        mem_re    = 1'b1;
        state_nxt = S_DBIT;
      end
      S_DBIT: begin
        acc_nxt  = {acc_r[BYTE_W-2:0], hit};
        addr_nxt = addr_r + CNT_W'(DUR_STEP);
        bit_nxt  = bit_r + 3'd1;
        if (bit_r == 3'd7) begin
          state_nxt = S_DEMIT;
        end else begin
          state_nxt = S_DRD;
        end
      end
      S_DEMIT: begin
        if (can_emit) begin
          emit_v    = 1'b1;
          emit_byte = acc_r;
          emit_last = last_data;
          i_nxt     = i_r + DC_W'(1);
          if (last_data) begin
            state_nxt = S_LOAD;
          end else begin
            state_nxt = S_DRD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      k_r         <= '0;
      rdv_r       <= 1'b0;
      h_r         <= HDR_LEN;
      bit_r       <= '0;
      i_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      k_r     <= k_nxt;
      rdv_r   <= rdv_nxt;
      h_r     <= h_nxt;
      bit_r   <= bit_nxt;
      i_r     <= i_nxt;
      if (can_emit) begin
        out_valid_r <= emit_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    fcnt_r   <= fcnt_nxt;
    dc_r     <= dc_nxt;
    smark_r  <= smark_nxt;
    sspace_r <= sspace_nxt;
    ssum_r   <= ssum_nxt;
    short_r  <= short_nxt;
    long_r   <= long_nxt;
    lsum_r   <= lsum_nxt;
    found_r  <= found_nxt;
    addr_r   <= addr_nxt;
    acc_r    <= acc_nxt;
    if (emit_v) begin
      out_byte_r <= emit_byte;
      out_bad_r  <= emit_bad;
      out_last_r <= emit_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_frame_bad = out_bad_r;
  assign out_last_byte = out_last_r;

endmodule

[hw/rtl/ipd_checker.sv]
// Port-level checker for the pulse distance IR decoder, bound to the top level.
// Depends on ipd_pkg and pulse_distance_ir_decoder_unit.
module ipd_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic [ipd_pkg::DUR_W-1:0]  in_duration,
  input logic                       in_frame_end,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [ipd_pkg::BYTE_W-1:0] out_byte,
  input logic                       out_frame_bad,
  input logic                       out_last_byte
);
  import ipd_pkg::*;

  logic in_take;
  assign in_take = in_valid && !in_stall;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) &&
      $stable(out_frame_bad) && $stable(out_last_byte))
    else $error("stalled output item changed");

  a_bad_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_bad |-> out_last_byte && out_byte == '0)
    else $error("rejected frame item not a lone zero item");

  a_load_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && !in_frame_end && in_duration == in_duration |=> !in_stall)
    else $error("input closed in the middle of a frame");

  a_frame_close: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && in_frame_end |=> in_stall)
    else $error("input still open after frame end");

endmodule

bind pulse_distance_ir_decoder_unit ipd_checker u_ipd_checker (.*);

[tb/pulse_distance_ir_decoder_unit_tb.sv]
// Testbench for pulse_distance_ir_decoder_unit: directed frame table, then random frames,
// each decoded record checked item by item against an in-bench frame decoder.
// Depends on ipd_pkg and the decoder RTL only.
module pulse_distance_ir_decoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ipd_pkg::*;

  localparam int STORE_DEPTH = DEF_MAX_DURATIONS;
  localparam int AVG_N       = DEF_AVERAGE_SAMPLES;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int RND_ITEMS   = 60;
  localparam int RND_FRAMES  = 3;

  typedef enum logic [2:0] {FK_ZERO, FK_MAX, FK_NOISE, FK_CODED, FK_FLAT, FK_ONES} frame_kind_t;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              bad;
    logic              last;
  } ir_byte_t;

  typedef struct packed {
    logic [7:0]  len;
    frame_kind_t kind;
    logic        reject;
  } frame_row_t;

  localparam ir_byte_t REJECTED = '{value: '0, bad: 1'b1, last: 1'b1};

  logic              clk;
  logic              rst_n        = 1'b0;
  logic              in_valid     = 1'b0;
  logic              in_stall;
  logic [DUR_W-1:0]  in_duration  = '0;
  logic              in_frame_end = 1'b0;
  logic              out_valid;
  logic              out_stall    = 1'b0;
  logic [BYTE_W-1:0] out_byte;
  logic              out_frame_bad;
  logic              out_last_byte;

  logic [DUR_W-1:0] dur_mem [STORE_DEPTH];
  int unsigned      dur_cnt = 0;
  bit               dur_ovf = 1'b0;

  ir_byte_t         record_q [$];
  logic [DUR_W-1:0] frame_q [$];
  int unsigned      fails = 0;
  int unsigned      send_idle_pct = 0;
  int unsigned      recv_idle_pct = 0;
  bit               hold_req = 1'b0;
  bit               hold_done = 1'b0;
  int unsigned      hold_left = 0;
  int unsigned      quiet_cycles = 0;

  frame_row_t dir_plan [3] = '{
    '{len: 8'd1,   kind: FK_ZERO,  reject: 1'b1},
    '{len: 8'd12,  kind: FK_NOISE, reject: 1'b1},
    '{len: 8'd68,  kind: FK_MAX,   reject: 1'b0}
  };

  pulse_distance_ir_decoder_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_duration   (in_duration),
    .in_frame_end  (in_frame_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_frame_bad (out_frame_bad),
    .out_last_byte (out_last_byte)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic ir_byte_t good_byte(input logic [BYTE_W-1:0] v, input logic last);
    return '{value: v, bad: 1'b0, last: last};
  endfunction

  function automatic void decode_duration(input logic [DUR_W-1:0] d, input logic fe,
                                          ref ir_byte_t recs [$]);
    int unsigned n, dcnt, short_len, long_len, twice, ssum, lsum, found, pos;
    logic [BYTE_W-1:0] bits;
    if (dur_cnt < STORE_DEPTH) begin
      dur_mem[dur_cnt] = d;
      dur_cnt++;
    end else begin
      dur_ovf = 1'b1;
    end
    if (!fe) return;
    n = dur_cnt;
    dur_cnt = 0;
    if (dur_ovf || n < MIN_DURATIONS || (n - FRAME_PHASE) % 8 != 0) begin
      dur_ovf = 1'b0;
      recs.push_back(REJECTED);
      return;
    end
    dcnt = (n - FRAME_PHASE) >> BYTE_DUR_SHIFT;
    ssum = 0;
    for (int i = 0; i < AVG_N; i++) ssum += dur_mem[FIRST_MARK_IDX + DUR_STEP * i];
    short_len = ssum / AVG_N;
    twice = 2 * short_len;
    lsum = 0;
    found = 0;
    pos = 0;
    do begin
      if (dur_mem[FIRST_SPACE_IDX + DUR_STEP * pos] > twice) begin
        lsum += dur_mem[FIRST_SPACE_IDX + DUR_STEP * pos];
        found++;
      end
      pos++;
    end while (found != AVG_N && FIRST_SPACE_IDX + DUR_STEP * pos <= n - SCAN_TAIL);
    long_len = (found != 0) ? lsum / found : 0;
    recs.push_back(good_byte(BYTE_W'(dcnt + HEAD_EXTRA), 1'b0));
    recs.push_back(good_byte(BYTE_W'(dur_mem[START_MARK_IDX]), 1'b0));
    recs.push_back(good_byte(BYTE_W'(dur_mem[START_SPACE_IDX]), 1'b0));
    recs.push_back(good_byte(BYTE_W'(short_len), 1'b0));
    recs.push_back(good_byte(BYTE_W'(long_len), dcnt == 0));
    recs.push_back(good_byte(BYTE_W'(dcnt), dcnt == 0));
    for (int unsigned i = 0; i < dcnt; i++) begin
      bits = '0;
      for (int j = 0; j < 8; j++)
        if (dur_mem[FIRST_SPACE_IDX + 16 * i + DUR_STEP * j] > twice) bits[7 - j] = 1'b1;
      recs.push_back(good_byte(bits, i + 1 == dcnt));
    end
  endfunction

  function automatic void build_frame(input int unsigned len, input frame_kind_t kind);
    int unsigned s, v;
    bit one;
    frame_q.delete();
    s = ($urandom_range(3) == 0) ? $urandom_range(30000, 1) : $urandom_range(600, 4);
    for (int unsigned i = 0; i < len; i++) begin
      case (kind)
        FK_ZERO:  v = 0;
        FK_MAX:   v = 32'hFFFF;
        FK_NOISE: v = $urandom_range(32'hFFFF);
        default: begin
          if (i < FIRST_MARK_IDX) begin
            v = $urandom_range(32'hFFFF);
          end else if (i % 2 == 1) begin
            v = s + $urandom_range(s / 8);
          end else begin
            one = (kind == FK_ONES) || (kind == FK_CODED && $urandom_range(1) == 1);
            v = one ? 3 * s + $urandom_range(s / 2) : s + $urandom_range(s / 8);
          end
        end
      endcase
      frame_q.push_back(v > 32'hFFFF ? 16'hFFFF : DUR_W'(v));
    end
  endfunction

  task automatic offer_frame(input bit reject);
    ir_byte_t got [$];
    for (int k = 0; k < frame_q.size(); k++) begin
      while ($urandom_range(99) < send_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid     <= 1'b1;
      in_duration  <= frame_q[k];
      in_frame_end <= (k == frame_q.size() - 1);
      do begin
        @(posedge clk);
      end while (in_stall);
      got.delete();
      decode_duration(frame_q[k], k == frame_q.size() - 1, got);
      if (reject && got.size() != 0) begin
        record_q.push_back(REJECTED);
      end else begin
        foreach (got[i]) record_q.push_back(got[i]);
      end
    end
  endtask

  always @(posedge clk) begin
    ir_byte_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (record_q.size() == 0) begin
          $error("out_byte: no item expected, got %0d", out_byte);
          fails++;
        end else begin
          want = record_q.pop_front();
          if (out_byte !== want.value) begin
            $error("out_byte: expected %0d, got %0d", want.value, out_byte);
            fails++;
          end
          if (out_frame_bad !== want.bad) begin
            $error("out_frame_bad: expected %0d, got %0d", want.bad, out_frame_bad);
            fails++;
          end
          if (out_last_byte !== want.last) begin
            $error("out_last_byte: expected %0d, got %0d", want.last, out_last_byte);
            fails++;
          end
        end
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned len, pick, rnd_items, rnd_frames;
    frame_kind_t kind;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 31;
    recv_idle_pct = 59;
    foreach (dir_plan[r]) begin
      build_frame(dir_plan[r].len, dir_plan[r].kind);
      offer_frame(dir_plan[r].reject);
      in_valid <= 1'b0;
      while (record_q.size() != 0) @(posedge clk);
    end

    rnd_items = 0;
    rnd_frames = 0;
    while (rnd_items < RND_ITEMS || rnd_frames < RND_FRAMES) begin
      if (rnd_frames < 2) begin
        send_idle_pct = 59;
        recv_idle_pct = 31;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (rnd_frames == 1) hold_req = 1'b1;
      pick = $urandom_range(9);
      kind = FK_CODED;
      if (pick < 5) begin
        len = 68;
        pick = $urandom_range(9);
        if (pick == 0) kind = FK_FLAT;
        else if (pick == 1) kind = FK_ONES;
      end else if (pick < 8) begin
        len = $urandom_range(20, 1);
        kind = FK_NOISE;
      end else begin
        len = $urandom_range(20, 1);
      end
      build_frame(len, kind);
      offer_frame(1'b0);
      rnd_items += len;
      rnd_frames++;
    end
    in_valid <= 1'b0;

    while (record_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0 && record_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
